@@ hw/rtl/ppm_p3_pkg.sv @@
// ============================================================================
// ppm_p3_pkg
// Shared types and codes for the PPM P3 text parser.
// ============================================================================
`default_nettype none

package ppm_p3_pkg;

    // Result kinds on the output tuser
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_NUM   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_ZERO_MAX  = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;

    // Characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_P     = 8'h50;

    localparam int unsigned COMP_W  = 16;
    localparam int unsigned LEVEL_W = 24;
    localparam int unsigned ACC_W   = 17;
    localparam int unsigned TDATA_W = 144;

    // Outcome of one parse step
    typedef enum logic [1:0] {
        RES_NONE,
        RES_HDR,
        RES_PIX,
        RES_ERR
    } t_res;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the input word
        logic step;      // commit one parse step
        logic sel_lf;    // parse a virtual LF instead of the latched byte
        logic last;      // last flag for a parse result
        logic load_pix;  // load the pixel result once the levels are ready
        logic load_end;  // load the end result and return to reset state
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_res res;
        logic in_error;
        logic line_start;
        logic eos;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ hw/rtl/ascii_ppm_p3_parser_core.sv @@
// ============================================================================
// ascii_ppm_p3_parser_core
// Each accepted byte is parsed in S_BYTE before the next byte is accepted.
// A byte that completes a pixel then waits in S_DIV while the bit-serial
// divider computes the three levels in turn. End of stream adds a closing
// LF and the end result, plus one division if that LF ends a pixel.
// Synchronous active-low reset returns the parser to the magic line.
// ============================================================================
`default_nettype none

module ascii_ppm_p3_parser_core
    import ppm_p3_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = 4096,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [7:0]         i_s_tdata,   // data_byte[7:0]
    input  wire logic               i_s_tlast,   // end_of_stream
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    // pixel_x[11:0], pixel_y[23:12], red_level[47:24], green_level[71:48],
    // blue_level[95:72], image_width[108:96], image_height[121:109],
    // max_value[137:122], status[140:138], zero pad[143:141]
    output logic [TDATA_W-1:0]      o_m_tdata,
    output logic [1:0]              o_m_tuser,   // kind[1:0]
    output logic                    o_m_tlast    // last
);

    t_cmd  cmd;
    t_stat stat;

    ppm_p3_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    ppm_p3_dp #(
        .MAX_DIMENSION(MAX_DIMENSION),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_byte    (i_s_tdata),
        .i_eos     (i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

endmodule

`default_nettype wire

@@ hw/rtl/ppm_p3_div.sv @@
// ============================================================================
// ppm_p3_div
// Restoring divider, one quotient bit per cycle, three components in turn.
// ============================================================================
`default_nettype none

module ppm_p3_div
    import ppm_p3_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [COMP_W-1:0]  i_comp0,
    input  wire logic [COMP_W-1:0]  i_comp1,
    input  wire logic [COMP_W-1:0]  i_comp2,
    input  wire logic [COMP_W-1:0]  i_max,
    output logic                    o_busy,
    output logic [LEVEL_W-1:0]      o_level0,
    output logic [LEVEL_W-1:0]      o_level1,
    output logic [LEVEL_W-1:0]      o_level2
);

    localparam int unsigned QW = COMP_W + FRACTION_BITS;
    localparam int unsigned CW = $clog2(QW + 1);

    logic [COMP_W-1:0]  r_comp [3];
    logic [COMP_W-1:0]  r_max;
    logic [QW-1:0]      r_dvd;
    logic [QW-1:0]      r_quo;
    logic [COMP_W:0]    r_rem;
    logic [CW-1:0]      r_cnt;
    logic [1:0]         r_idx;
    logic               r_busy;
    logic [LEVEL_W-1:0] r_level [3];

    logic [COMP_W:0]    rem_sh;
    logic               qbit;
    logic [COMP_W:0]    n_rem;
    logic [QW-1:0]      n_quo;
    logic [LEVEL_W-1:0] sat_level;

    // One restoring step
    always_comb begin
        rem_sh    = {r_rem[COMP_W-1:0], r_dvd[QW-1]};
        qbit      = (rem_sh >= {1'b0, r_max});
        n_rem     = qbit ? (rem_sh - {1'b0, r_max}) : rem_sh;
        n_quo     = {r_quo[QW-2:0], qbit};
        sat_level = (n_quo > QW'({LEVEL_W{1'b1}})) ? {LEVEL_W{1'b1}} : n_quo[LEVEL_W-1:0];
    end

    // Advance the division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy    <= 1'b1;
            r_comp[0] <= i_comp0;
            r_comp[1] <= i_comp1;
            r_comp[2] <= i_comp2;
            r_max     <= i_max;
            r_dvd     <= QW'(i_comp0) << FRACTION_BITS;
            r_quo     <= '0;
            r_rem     <= '0;
            r_cnt     <= '0;
            r_idx     <= 2'd0;
        end else if (r_busy) begin
            if (r_cnt == CW'(QW - 1)) begin
                r_level[r_idx] <= sat_level;
                r_rem          <= '0;
                r_quo          <= '0;
                r_cnt          <= '0;
                if (r_idx == 2'd2) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                    r_dvd <= QW'(r_comp[r_idx + 2'd1]) << FRACTION_BITS;
                end
            end else begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_level0 = r_level[0];
    assign o_level1 = r_level[1];
    assign o_level2 = r_level[2];

endmodule

`default_nettype wire

@@ hw/rtl/ppm_p3_dp.sv @@
// ============================================================================
// ppm_p3_dp
// Parser datapath: token and header state, pixel counters, output register.
// ============================================================================
`default_nettype none

module ppm_p3_dp
    import ppm_p3_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = 4096,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_eos,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [TDATA_W-1:0]      o_m_tdata,
    output logic [1:0]              o_m_tuser,
    output logic                    o_m_tlast
);

    localparam int unsigned DW = $clog2(MAX_DIMENSION + 1);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_DIMS,
        PH_SCALE,
        PH_PIXELS,
        PH_ERROR
    } t_phase;

    // Parse state
    t_phase            r_phase,  n_phase;
    logic [ACC_W-1:0]  r_acc,    n_acc;
    logic              r_in,     n_in;
    logic              r_bad,    n_bad;
    logic              r_done,   n_done;
    logic              r_ls,     n_ls;
    logic              r_skip,   n_skip;
    logic [DW-1:0]     r_w,      n_w;
    logic [DW-1:0]     r_h,      n_h;
    logic [COMP_W-1:0] r_max,    n_max;
    logic [COMP_W-1:0] r_hold0,  n_hold0;
    logic [COMP_W-1:0] r_hold1,  n_hold1;
    logic [1:0]        r_cc,     n_cc;
    logic [DW-1:0]     r_col,    n_col;
    logic [DW-1:0]     r_row,    n_row;

    logic [7:0]        r_byte;
    logic              r_eos;
    logic [DW-1:0]     r_pix_x;
    logic [DW-1:0]     r_pix_y;

    t_res              res;
    logic [2:0]        res_st;
    logic [7:0]        ch;
    logic              digit;
    logic [20:0]       acc_next;
    logic [COMP_W-1:0] comp;
    logic [DW:0]       col_inc;

    logic              div_busy;
    logic [LEVEL_W-1:0] lv0, lv1, lv2;

    // Output register
    logic              r_ovalid;
    logic [1:0]        r_okind;
    logic [DW-1:0]     r_ox, r_oy;
    logic [LEVEL_W-1:0] r_or, r_og, r_ob;
    logic [DW-1:0]     r_ow, r_oh;
    logic [COMP_W-1:0] r_omax;
    logic [2:0]        r_ost;
    logic              r_olast;
    logic              out_free;

    assign out_free = !r_ovalid || i_m_tready;

    // One parse step on the selected character
    always_comb begin
        n_phase = r_phase; n_acc = r_acc; n_in = r_in; n_bad = r_bad;
        n_done = r_done; n_ls = r_ls; n_skip = r_skip; n_w = r_w; n_h = r_h;
        n_max = r_max; n_hold0 = r_hold0; n_hold1 = r_hold1; n_cc = r_cc;
        n_col = r_col; n_row = r_row;
        res    = RES_NONE;
        res_st = ST_OK;
        ch       = i_cmd.sel_lf ? CH_LF : r_byte;
        digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
        acc_next = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 21'(ch[3:0]);
        comp     = (r_acc > ACC_W'({COMP_W{1'b1}})) ? {COMP_W{1'b1}} : r_acc[COMP_W-1:0];
        col_inc  = {1'b0, r_col} + (DW+1)'(1);

        if (r_phase != PH_ERROR) begin
            if (ch == CH_LF || ch == CH_SPACE) begin
                if (ch == CH_SPACE) begin
                    n_ls = 1'b0;
                end
                // Close the open token
                if (r_in) begin
                    n_in = 1'b0; n_bad = 1'b0; n_done = 1'b0; n_acc = '0;
                    case (r_phase)
                        PH_MAGIC: begin
                            if (r_acc != ACC_W'(2)) begin
                                res = RES_ERR; res_st = ST_BAD_MAGIC; n_phase = PH_ERROR;
                            end else begin
                                n_phase = PH_DIMS; n_skip = 1'b1; n_cc = 2'd0;
                            end
                        end
                        PH_DIMS: begin
                            if (r_bad || r_acc > ACC_W'(MAX_DIMENSION)) begin
                                res = RES_ERR; res_st = ST_BAD_NUM; n_phase = PH_ERROR;
                            end else if (r_cc == 2'd0) begin
                                n_w  = r_acc[DW-1:0];
                                n_cc = 2'd1;
                            end else begin
                                n_h = r_acc[DW-1:0]; n_phase = PH_SCALE;
                                n_skip = 1'b1; n_cc = 2'd0;
                            end
                        end
                        PH_SCALE: begin
                            if (r_bad || r_acc > ACC_W'({COMP_W{1'b1}})) begin
                                res = RES_ERR; res_st = ST_BAD_NUM; n_phase = PH_ERROR;
                            end else if (r_acc == '0) begin
                                res = RES_ERR; res_st = ST_ZERO_MAX; n_phase = PH_ERROR;
                            end else begin
                                n_max = r_acc[COMP_W-1:0]; n_phase = PH_PIXELS;
                                n_skip = 1'b1; n_cc = 2'd0; n_col = '0; n_row = '0;
                                res = RES_HDR;
                            end
                        end
                        PH_PIXELS: begin
                            if (r_bad) begin
                                res = RES_ERR; res_st = ST_BAD_NUM; n_phase = PH_ERROR;
                            end else if (r_cc == 2'd0) begin
                                n_hold0 = comp; n_cc = 2'd1;
                            end else if (r_cc == 2'd1) begin
                                n_hold1 = comp; n_cc = 2'd2;
                            end else begin
                                n_cc = 2'd0;
                                if (r_w == '0 || r_row >= r_h) begin
                                    res = RES_ERR; res_st = ST_OVERFLOW; n_phase = PH_ERROR;
                                end else begin
                                    res = RES_PIX;
                                    if (col_inc >= {1'b0, r_w}) begin
                                        n_col = '0;
                                        n_row = r_row + DW'(1);
                                    end else begin
                                        n_col = col_inc[DW-1:0];
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                // Line end checks
                if (ch == CH_LF && n_phase != PH_ERROR) begin
                    if (n_skip) begin
                        n_skip = 1'b0;
                    end else if (n_phase == PH_MAGIC) begin
                        res = RES_ERR; res_st = ST_BAD_MAGIC; n_phase = PH_ERROR;
                    end else if (n_phase == PH_DIMS || n_phase == PH_SCALE) begin
                        res = RES_ERR; res_st = ST_BAD_NUM; n_phase = PH_ERROR;
                    end
                    n_ls = 1'b1;
                end
            end else begin
                n_ls = 1'b0;
                if (r_skip) begin
                    n_skip = 1'b1;
                end else if (r_ls && ch == CH_HASH && r_phase != PH_MAGIC) begin
                    n_skip = 1'b1;
                end else if (!r_in) begin
                    n_in = 1'b1;
                    if (r_phase == PH_MAGIC) begin
                        n_acc = (ch == CH_P) ? ACC_W'(1) : ACC_W'(3);
                    end else if (digit) begin
                        n_acc = ACC_W'(ch[3:0]);
                    end else begin
                        n_acc = '0;
                        n_bad = 1'b1;
                    end
                end else if (r_phase == PH_MAGIC) begin
                    n_acc = (r_acc == ACC_W'(1) && ch == CH_THREE) ? ACC_W'(2) : ACC_W'(3);
                end else if (!(r_bad || r_done)) begin
                    if (digit) begin
                        n_acc = (acc_next > 21'({ACC_W{1'b1}})) ? {ACC_W{1'b1}}
                                                               : acc_next[ACC_W-1:0];
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
        end
    end

    // Hold parse state; commit on step, clear on reset and at end of stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_end) begin
            r_phase <= PH_MAGIC; r_acc <= '0; r_in <= 1'b0; r_bad <= 1'b0;
            r_done <= 1'b0; r_ls <= 1'b1; r_skip <= 1'b0; r_w <= '0; r_h <= '0;
            r_max <= '0; r_hold0 <= '0; r_hold1 <= '0; r_cc <= 2'd0;
            r_col <= '0; r_row <= '0;
        end else if (i_cmd.step) begin
            r_phase <= n_phase; r_acc <= n_acc; r_in <= n_in; r_bad <= n_bad;
            r_done <= n_done; r_ls <= n_ls; r_skip <= n_skip; r_w <= n_w; r_h <= n_h;
            r_max <= n_max; r_hold0 <= n_hold0; r_hold1 <= n_hold1; r_cc <= n_cc;
            r_col <= n_col; r_row <= n_row;
        end
    end

    // Latch input word and pixel position
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte <= i_byte;
            r_eos  <= i_eos;
        end
        if (i_cmd.step && res == RES_PIX) begin
            r_pix_x <= r_col;
            r_pix_y <= r_row;
        end
    end

    ppm_p3_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.step && res == RES_PIX),
        .i_comp0 (r_hold0),
        .i_comp1 (r_hold1),
        .i_comp2 (comp),
        .i_max   (r_max),
        .o_busy  (div_busy),
        .o_level0(lv0),
        .o_level1(lv1),
        .o_level2(lv2)
    );

    // Load and drain the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.step && (res == RES_HDR || res == RES_ERR)) begin
            r_ovalid <= 1'b1;
            r_okind  <= (res == RES_HDR) ? KIND_HEADER : KIND_ERROR;
            r_ox <= '0; r_oy <= '0; r_or <= '0; r_og <= '0; r_ob <= '0;
            r_ow <= n_w; r_oh <= n_h; r_omax <= n_max;
            r_ost    <= res_st;
            r_olast  <= i_cmd.last;
        end else if (i_cmd.load_pix) begin
            r_ovalid <= 1'b1;
            r_okind  <= KIND_PIXEL;
            r_ox <= r_pix_x; r_oy <= r_pix_y; r_or <= lv0; r_og <= lv1; r_ob <= lv2;
            r_ow <= r_w; r_oh <= r_h; r_omax <= r_max;
            r_ost    <= ST_OK;
            r_olast  <= i_cmd.last;
        end else if (i_cmd.load_end) begin
            r_ovalid <= 1'b1;
            if (r_phase == PH_MAGIC || r_phase == PH_DIMS || r_phase == PH_SCALE) begin
                r_okind <= KIND_ERROR;
                r_ost   <= ST_TRUNC;
            end else begin
                r_okind <= KIND_END;
                r_ost   <= ST_OK;
            end
            r_ox <= '0; r_oy <= '0; r_or <= '0; r_og <= '0; r_ob <= '0;
            r_ow <= r_w; r_oh <= r_h; r_omax <= r_max;
            r_olast  <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {3'b000, r_ost, r_omax, 13'(r_oh), 13'(r_ow),
                         r_ob, r_og, r_or, 12'(r_oy), 12'(r_ox)};

    assign o_stat.res        = res;
    assign o_stat.in_error   = (r_phase == PH_ERROR);
    assign o_stat.line_start = r_ls;
    assign o_stat.eos        = r_eos;
    assign o_stat.div_busy   = div_busy;
    assign o_stat.out_free   = out_free;

endmodule

`default_nettype wire

@@ hw/rtl/ppm_p3_ctrl.sv @@
// ============================================================================
// ppm_p3_ctrl
// Sequencer: byte step, level division, closing LF and end-of-stream result.
// ============================================================================
`default_nettype none

module ppm_p3_ctrl
    import ppm_p3_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_tvalid,
    output logic       o_s_tready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTE,
        S_DIV,
        S_LF,
        S_END
    } t_state;

    t_state r_state;
    logic   r_lf_pass;

    // Decode commands from state
    always_comb begin
        o_cmd          = '0;
        o_cmd.sel_lf   = (r_state == S_LF);
        o_cmd.last     = (r_state == S_LF || (r_state == S_DIV && r_lf_pass)) ? 1'b0
                                                                             : !i_stat.eos;
        case (r_state)
            S_IDLE:  o_cmd.capture  = i_s_tvalid;
            S_BYTE:  o_cmd.step     = i_stat.out_free;
            S_DIV:   o_cmd.load_pix = !i_stat.div_busy && i_stat.out_free;
            S_LF:    o_cmd.step     = !i_stat.in_error && !i_stat.line_start
                                      && i_stat.out_free;
            S_END:   o_cmd.load_end = i_stat.out_free;
            default: o_cmd          = '0;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

    // Advance the sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_lf_pass <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_BYTE;
                    end
                end
                S_BYTE: begin
                    if (i_stat.out_free) begin
                        r_lf_pass <= 1'b0;
                        if (i_stat.res == RES_PIX) begin
                            r_state <= S_DIV;
                        end else begin
                            r_state <= i_stat.eos ? S_LF : S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    if (!i_stat.div_busy && i_stat.out_free) begin
                        if (r_lf_pass) begin
                            r_state <= S_END;
                        end else begin
                            r_state <= i_stat.eos ? S_LF : S_IDLE;
                        end
                    end
                end
                S_LF: begin
                    if (i_stat.in_error || i_stat.line_start) begin
                        r_state <= S_END;
                    end else if (i_stat.out_free) begin
                        r_lf_pass <= 1'b1;
                        r_state   <= (i_stat.res == RES_PIX) ? S_DIV : S_END;
                    end
                end
                S_END: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
